// ===== rtl/bbss_pkg.sv =====
// bbss_pkg: shared types and constants of the buck-boost switch sequencer
// mode codes, command codes, register indexes and the result word layout
// no dependencies
package bbss_pkg;

  // register file
  localparam int CFG_WIDTH = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_DELAY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_DELAY  = 1'b1;

  localparam logic [CFG_WIDTH-1:0] SHORT_DELAY_RST = 16'd100;
  localparam logic [CFG_WIDTH-1:0] SOFT_DELAY_RST  = 16'd700;

  // command codes
  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // converter modes
  typedef enum logic [2:0] {
    MODE_ALLOFF    = 3'd0,
    MODE_BUCKOFF   = 3'd1,
    MODE_BUCKSOFT  = 3'd2,
    MODE_BUCKON    = 3'd3,
    MODE_BOOSTOFF  = 3'd4,
    MODE_BOOSTSOFT = 3'd5,
    MODE_BOOSTON   = 3'd6,
    MODE_DISCHARGE = 3'd7
  } mode_t;

  // one result word
  typedef struct packed {
    logic [3:0] switch_drive;
    mode_t      current_mode;
    logic       delay_pending;
  } bbss_word_t;

endpackage

// ===== rtl/bbss_in_if.sv =====
// bbss_in_if: input channel, one command word per handshake
// valid/ready handshake; no dependencies
interface bbss_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [2:0] requested_mode;

  modport source (output valid, output command, output requested_mode, input ready);
  modport sink   (input valid, input command, input requested_mode, output ready);
endinterface

// ===== rtl/bbss_out_if.sv =====
// bbss_out_if: result channel, one switch status word per handshake
// valid/ready handshake; no dependencies
interface bbss_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] switch_drive;
  logic [2:0] current_mode;
  logic       delay_pending;

  modport source (output valid, output switch_drive, output current_mode,
                  output delay_pending, input ready);
  modport sink   (input valid, input switch_drive, input current_mode,
                  input delay_pending, output ready);
endinterface

// ===== rtl/buck_boost_switch_sequencer.sv =====
// Four-switch buck-boost switch sequencer: takes one command word (set mode or
// timer tick) per clock and returns one word per command with the switch
// lines, the mode held and whether a countdown is armed. The result of a word
// is registered before it is shown, later still while the result side stalls;
// a two-entry output buffer keeps the input open while one result waits, so a
// word can enter in every cycle, and the input is held off only while both
// entries are full.
// A delay register wider than the countdown (DELAY_WIDTH) saturates on load.
// depends on bbss_pkg, bbss_in_if, bbss_out_if and bbss_core
module buck_boost_switch_sequencer #(
  parameter int DELAY_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bbss_in_if.sink                        in_ch,
  bbss_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [bbss_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bbss_pkg::CFG_WIDTH-1:0] cfg_data
);
  import bbss_pkg::*;

  logic       acc;
  logic       pop;
  bbss_word_t word_nxt;
  bbss_word_t head_r, skid_r;
  logic       head_valid_r, skid_valid_r;

  assign in_ch.ready = !skid_valid_r;
  assign acc         = in_ch.valid && in_ch.ready;
  assign pop         = head_valid_r && out_ch.ready;

  bbss_core #(
    .DELAY_WIDTH(DELAY_WIDTH)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .acc            (acc),
    .command        (in_ch.command),
    .requested_mode (in_ch.requested_mode),
    .word_nxt       (word_nxt)
  );

  // output buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!head_valid_r || pop) begin
        head_valid_r <= skid_valid_r || acc;
        skid_valid_r <= 1'b0;
      end else if (acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // output buffer payload
  always_ff @(posedge clk) begin
    if (!head_valid_r || pop) begin
      if (skid_valid_r) head_r <= skid_r;
      else if (acc)     head_r <= word_nxt;
    end else if (acc) begin
      skid_r <= word_nxt;
    end
  end

  assign out_ch.valid         = head_valid_r;
  assign out_ch.switch_drive  = head_r.switch_drive;
  assign out_ch.current_mode  = head_r.current_mode;
  assign out_ch.delay_pending = head_r.delay_pending;

`ifndef ASSERT_OFF
  // the skid entry is only used behind a waiting head
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> head_valid_r)
    else $error("skid entry valid without head entry");

  // a word accepted into an empty buffer shows up next cycle
  a_acc_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !head_valid_r) |=> head_valid_r)
    else $error("accepted word did not reach the output");

  // all-off mode never drives a switch
  a_alloff_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (head_valid_r && head_r.current_mode == MODE_ALLOFF) |-> head_r.switch_drive == 4'h0)
    else $error("switches driven in all-off mode");
`endif

endmodule

// ===== rtl/bbss_core.sv =====
// bbss_core: mode, switch and countdown state with the per-word update logic
// holds the delay registers; depends on bbss_pkg
module bbss_core #(
  parameter int DELAY_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bbss_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bbss_pkg::CFG_WIDTH-1:0] cfg_data,
  input  logic                           acc,
  input  logic                           command,
  input  logic [2:0]                     requested_mode,
  output bbss_pkg::bbss_word_t           word_nxt
);
  import bbss_pkg::*;

  localparam int ExtW = (DELAY_WIDTH > CFG_WIDTH) ? DELAY_WIDTH : CFG_WIDTH;
  localparam logic [DELAY_WIDTH-1:0] CntMax = '1;
  localparam logic [DELAY_WIDTH-1:0] CntOne = DELAY_WIDTH'(1);

  // switch bits
  localparam logic [3:0] SW_BUCK_LO  = 4'h1;
  localparam logic [3:0] SW_BUCK_HI  = 4'h2;
  localparam logic [3:0] SW_BOOST_LO = 4'h4;
  localparam logic [3:0] SW_BOOST_HI = 4'h8;

  // final patterns at expiry
  localparam logic [3:0] PAT_BUCKOFF   = 4'h9;
  localparam logic [3:0] PAT_BUCKON    = 4'hA;
  localparam logic [3:0] PAT_BOOSTOFF  = 4'hA;
  localparam logic [3:0] PAT_BOOSTON   = 4'h6;
  localparam logic [3:0] PAT_DISCHARGE = 4'h5;

  logic [CFG_WIDTH-1:0]   short_r, soft_r;
  mode_t                  mode_r, mode_nxt;
  logic [3:0]             lines_r, lines_nxt;
  logic [DELAY_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                   armed_r, armed_nxt;
  logic [DELAY_WIDTH-1:0] short_ld, soft_ld;
  mode_t                  req;

  // break before make in one half-bridge
  function automatic logic [3:0] half_bridge(input logic [3:0] lines,
                                              input logic [3:0] opp,
                                              input logic [3:0] tgt);
    logic [3:0] res;
    if ((lines & opp) != 4'h0) res = lines & ~opp;
    else                       res = lines | tgt;
    return res;
  endfunction

  // delay register saturated to the countdown width
  function automatic logic [DELAY_WIDTH-1:0] sat_load(input logic [CFG_WIDTH-1:0] v);
    logic [ExtW-1:0] ext;
    logic [DELAY_WIDTH-1:0] res;
    ext = ExtW'(v);
    if (ext > ExtW'(CntMax)) res = CntMax;
    else                     res = ext[DELAY_WIDTH-1:0];
    return res;
  endfunction

  assign short_ld = sat_load(short_r);
  assign soft_ld  = sat_load(soft_r);
  assign req      = mode_t'(requested_mode);

  // delay registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r <= SHORT_DELAY_RST;
      soft_r  <= SOFT_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SHORT_DELAY: short_r <= cfg_data;
        CFG_SOFT_DELAY:  soft_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state for one accepted word
  always_comb begin
    mode_nxt  = mode_r;
    lines_nxt = lines_r;
    cnt_nxt   = cnt_r;
    armed_nxt = armed_r;
    if (acc) begin
      if (command == CMD_SET) begin
        unique case (req)
          MODE_BUCKOFF: begin
            lines_nxt = half_bridge(lines_nxt, SW_BUCK_HI, SW_BUCK_LO);
            lines_nxt = half_bridge(lines_nxt, SW_BOOST_LO, SW_BOOST_HI);
          end
          MODE_BUCKSOFT: begin
            lines_nxt = lines_nxt & ~(SW_BUCK_LO | SW_BUCK_HI);
            lines_nxt = half_bridge(lines_nxt, SW_BOOST_LO, SW_BOOST_HI);
          end
          MODE_BUCKON, MODE_BOOSTOFF: begin
            lines_nxt = half_bridge(lines_nxt, SW_BUCK_LO, SW_BUCK_HI);
            lines_nxt = half_bridge(lines_nxt, SW_BOOST_LO, SW_BOOST_HI);
          end
          MODE_BOOSTSOFT: begin
            lines_nxt = half_bridge(lines_nxt, SW_BUCK_LO, SW_BUCK_HI);
            lines_nxt = lines_nxt & ~(SW_BOOST_LO | SW_BOOST_HI);
          end
          MODE_BOOSTON: begin
            lines_nxt = half_bridge(lines_nxt, SW_BUCK_LO, SW_BUCK_HI);
            lines_nxt = half_bridge(lines_nxt, SW_BOOST_HI, SW_BOOST_LO);
          end
          MODE_DISCHARGE: begin
            lines_nxt = half_bridge(lines_nxt, SW_BUCK_HI, SW_BUCK_LO);
            lines_nxt = half_bridge(lines_nxt, SW_BOOST_HI, SW_BOOST_LO);
          end
          default: lines_nxt = 4'h0;
        endcase
        // only a change of mode arms the dead time
        if (req != mode_r) begin
          cnt_nxt   = short_ld;
          armed_nxt = 1'b1;
          mode_nxt  = req;
        end
      end else if (armed_r) begin
        if (cnt_r <= CntOne) begin
          cnt_nxt   = '0;
          armed_nxt = 1'b0;
          unique case (mode_r)
            MODE_BUCKOFF: begin
              lines_nxt = lines_r | PAT_BUCKOFF;
              cnt_nxt   = soft_ld;
              armed_nxt = 1'b1;
              mode_nxt  = MODE_BUCKSOFT;
            end
            MODE_BUCKSOFT:  lines_nxt = (lines_r & ~SW_BUCK_LO) | SW_BOOST_HI;
            MODE_BUCKON:    lines_nxt = lines_r | PAT_BUCKON;
            MODE_BOOSTOFF: begin
              lines_nxt = lines_r | PAT_BOOSTOFF;
              cnt_nxt   = soft_ld;
              armed_nxt = 1'b1;
              mode_nxt  = MODE_BOOSTSOFT;
            end
            MODE_BOOSTSOFT: lines_nxt = (lines_r & ~SW_BOOST_HI) | SW_BUCK_HI;
            MODE_BOOSTON:   lines_nxt = lines_r | PAT_BOOSTON;
            MODE_DISCHARGE: lines_nxt = lines_r | PAT_DISCHARGE;
            default: ;
          endcase
        end else begin
          cnt_nxt = cnt_r - CntOne;
        end
      end
    end
  end

  // converter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_ALLOFF;
      lines_r <= 4'h0;
      cnt_r   <= '0;
      armed_r <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      lines_r <= lines_nxt;
      cnt_r   <= cnt_nxt;
      armed_r <= armed_nxt;
    end
  end

  assign word_nxt.switch_drive  = lines_nxt;
  assign word_nxt.current_mode  = mode_nxt;
  assign word_nxt.delay_pending = armed_nxt;

endmodule
